// File: sv/bhil_pkg.sv
`timescale 1ns / 1ps
// Package for the header id lookup block: payload structs, register map,
// parse phases, status codes and header constants. No dependencies.
package bhil_pkg;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [31:0] MAGIC_WORD  = 32'h4448_434c;
    localparam logic [31:0] LONG_ID_BIT = 32'h0000_0080;
    localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_SECTION_NAME = 2'd0,
        REG_ID_NAME      = 2'd1,
        REG_WANT_LONG    = 2'd2,
        REG_LONG_SIZE    = 2'd3
    } t_reg_idx;

    localparam logic [2:0] ST_VALUE         = 3'd0;
    localparam logic [2:0] ST_LONG_DATA     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND     = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC     = 3'd3;
    localparam logic [2:0] ST_ZERO_SECTION  = 3'd4;
    localparam logic [2:0] ST_SIZE_MISMATCH = 3'd5;

    typedef enum logic [7:0] {
        PH_HSIZE   = 8'b0000_0001,
        PH_SECNAME = 8'b0000_0010,
        PH_SECSIZE = 8'b0000_0100,
        PH_ID      = 8'b0000_1000,
        PH_MATCHED = 8'b0001_0000,
        PH_NSIZE   = 8'b0010_0000,
        PH_SKIP    = 8'b0100_0000,
        PH_DATA    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [31:0] header_word;
        logic        first_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [2:0]  byte_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] section_name;
        logic [31:0] id_name;
        logic        want_long;
        logic [15:0] long_size;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] word_pos;
        logic [31:0] header_end;
        logic [31:0] section_end;
        logic        section_matched;
        logic [31:0] skip_left;
        logic [15:0] data_left;
        logic        finished;
    } t_parse_state;

endpackage

// File: sv/block_header_id_lookup.sv
`timescale 1ns / 1ps
// Header id lookup top level: one header word per cycle, input register,
// one pass of bhil_next, result register. A word is held in the input
// register and its result in the result register; one word is taken every
// cycle unless a held result is stalled by the receiver.
// Synchronous active-low reset clears the configuration and valid flags and
// leaves the block idle, ignoring words until a first word arrives. Depends on bhil_pkg.
module block_header_id_lookup (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  bhil_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output bhil_pkg::t_out_item                   o_out_item,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bhil_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [bhil_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [bhil_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    bhil_pkg::t_cfg         r_cfg;
    bhil_pkg::t_parse_state r_state;
    bhil_pkg::t_parse_state n_state;
    bhil_pkg::t_in_item     r_in;
    bhil_pkg::t_out_item    r_out;
    bhil_pkg::t_out_item    w_res;
    logic                   r_in_vld;
    logic                   r_out_vld;
    logic                   w_res_vld;
    logic                   w_proc;
    logic                   w_cfg_wr;
    bhil_pkg::t_reg_idx     w_reg;

    // The held word is processed once the result register has room for it.
    assign w_proc      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_proc;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign w_reg       = bhil_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            bhil_pkg::REG_SECTION_NAME: prdata = r_cfg.section_name;
            bhil_pkg::REG_ID_NAME:      prdata = r_cfg.id_name;
            bhil_pkg::REG_WANT_LONG:    prdata = {31'd0, r_cfg.want_long};
            bhil_pkg::REG_LONG_SIZE:    prdata = {16'd0, r_cfg.long_size};
        endcase
    end

    bhil_next u_next (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .o_state     (n_state),
        .o_res_valid (w_res_vld),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{phase: bhil_pkg::PH_HSIZE, word_pos: 32'd0, header_end: 32'd0,
                           section_end: 32'd0, section_matched: 1'b0, skip_left: 32'd0,
                           data_left: 16'd0, finished: 1'b1};
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg)
                    bhil_pkg::REG_SECTION_NAME: r_cfg.section_name <= pwdata;
                    bhil_pkg::REG_ID_NAME:      r_cfg.id_name      <= pwdata;
                    bhil_pkg::REG_WANT_LONG:    r_cfg.want_long    <= pwdata[0];
                    bhil_pkg::REG_LONG_SIZE:    r_cfg.long_size    <= pwdata[15:0];
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (w_proc) begin
                r_in_vld <= 1'b0;
            end
            if (w_proc) begin
                r_state   <= n_state;
                r_out_vld <= w_res_vld;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (w_proc && w_res_vld) begin
            r_out <= w_res;
        end
    end

    // A final result always leaves the walk idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_res_vld && w_res.last) |=> r_state.finished)
        else $error("search not finished after final result");

    // Only long data results carry a byte count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == bhil_pkg::ST_LONG_DATA
                         || o_out_item.byte_count == 3'd0))
        else $error("byte count on a non-data result");

    // While data words are due, some bytes remain.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == bhil_pkg::PH_DATA && !r_state.finished)
        |-> (r_state.data_left != 16'd0))
        else $error("data phase with no bytes left");

    // A good magic word restarts the walk at the header size word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.first_word && r_in.header_word == bhil_pkg::MAGIC_WORD)
        |=> (!r_state.finished && r_state.phase == bhil_pkg::PH_HSIZE
             && r_state.word_pos == 32'd1))
        else $error("restart did not reset the walk");

    // A new result only ever comes from a processed word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_proc))
        else $error("result without a processed item");

endmodule

// File: sv/bhil_next.sv
`timescale 1ns / 1ps
// Next-state and result logic of the header walk for one header word.
// Purely combinational; uses bhil_pkg types and constants.
module bhil_next (
    input  bhil_pkg::t_parse_state i_state,
    input  bhil_pkg::t_in_item     i_item,
    input  bhil_pkg::t_cfg         i_cfg,
    output bhil_pkg::t_parse_state o_state,
    output logic                   o_res_valid,
    output bhil_pkg::t_out_item    o_res
);

    logic [31:0] w;
    logic [31:0] swapped;
    logic [31:0] wp_inc;
    logic [31:0] wp_dec;
    logic [32:0] sec_end_full;
    logic [32:0] target;
    logic [31:0] t_sat;
    logic [31:0] skip_dec;
    logic [31:0] id_match;
    logic [2:0]  data_n;
    logic        do_land;

    assign w       = i_item.header_word;
    assign swapped = {w[7:0], w[15:8], w[23:16], w[31:24]};
    assign wp_inc  = (i_state.word_pos == bhil_pkg::POS_MAX) ? i_state.word_pos
                                                             : i_state.word_pos + 32'd1;
    assign wp_dec  = i_state.word_pos - 32'd1;
    // Section end counts from the section name word, one word before this one.
    assign sec_end_full = {1'b0, wp_dec} + {3'b000, swapped[31:2]};
    assign id_match = i_cfg.want_long ? (i_cfg.id_name | bhil_pkg::LONG_ID_BIT)
                                      : i_cfg.id_name;
    assign skip_dec = (i_state.skip_left != 32'd0) ? i_state.skip_left - 32'd1
                                                   : i_state.skip_left;
    assign data_n   = (i_state.data_left > 16'd4) ? 3'd4 : i_state.data_left[2:0];
    assign t_sat    = target[32] ? bhil_pkg::POS_MAX : target[31:0];

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        do_land     = 1'b0;
        target      = '0;

        if (i_item.first_word) begin
            o_state.finished        = 1'b0;
            o_state.section_matched = 1'b0;
            o_state.word_pos        = 32'd1;
            o_state.phase           = bhil_pkg::PH_HSIZE;
            if (w != bhil_pkg::MAGIC_WORD) begin
                o_res_valid       = 1'b1;
                o_res.status      = bhil_pkg::ST_BAD_MAGIC;
                o_res.last        = 1'b1;
                o_state.finished  = 1'b1;
            end
        end else if (!i_state.finished) begin
            o_state.word_pos = wp_inc;
            unique case (i_state.phase)
                bhil_pkg::PH_HSIZE: begin
                    o_state.header_end      = {2'b00, swapped[31:2]};
                    o_state.section_matched = 1'b0;
                    do_land                 = 1'b1;
                    target                  = {1'b0, wp_inc};
                end
                bhil_pkg::PH_SECNAME: begin
                    o_state.section_matched = (w == i_cfg.section_name);
                    o_state.phase           = bhil_pkg::PH_SECSIZE;
                end
                bhil_pkg::PH_SECSIZE: begin
                    if (swapped == 32'd0) begin
                        o_res_valid      = 1'b1;
                        o_res.status     = bhil_pkg::ST_ZERO_SECTION;
                        o_res.last       = 1'b1;
                        o_state.finished = 1'b1;
                    end else begin
                        o_state.section_end = sec_end_full[32] ? bhil_pkg::POS_MAX
                                                               : sec_end_full[31:0];
                        do_land = 1'b1;
                        if (i_state.section_matched) begin
                            target = {1'b0, wp_inc};
                        end else begin
                            target = (sec_end_full > {1'b0, wp_inc}) ? sec_end_full
                                                                     : {1'b0, wp_inc};
                        end
                    end
                end
                bhil_pkg::PH_ID: begin
                    if (w == id_match) begin
                        o_state.phase = bhil_pkg::PH_MATCHED;
                    end else if ((w & bhil_pkg::LONG_ID_BIT) != 32'd0) begin
                        o_state.phase = bhil_pkg::PH_NSIZE;
                    end else begin
                        // A short id is the name word plus one value word.
                        do_land = 1'b1;
                        target  = {1'b0, wp_inc} + 33'd1;
                    end
                end
                bhil_pkg::PH_MATCHED: begin
                    o_res_valid      = 1'b1;
                    o_res.last       = 1'b1;
                    o_state.finished = 1'b1;
                    if (!i_cfg.want_long) begin
                        o_res.status = bhil_pkg::ST_VALUE;
                        o_res.value  = swapped;
                    end else if (swapped != {16'd0, i_cfg.long_size}) begin
                        o_res.status = bhil_pkg::ST_SIZE_MISMATCH;
                    end else if (i_cfg.long_size == 16'd0) begin
                        o_res.status = bhil_pkg::ST_LONG_DATA;
                    end else begin
                        o_res_valid       = 1'b0;
                        o_res.last        = 1'b0;
                        o_state.finished  = 1'b0;
                        o_state.data_left = i_cfg.long_size;
                        o_state.phase     = bhil_pkg::PH_DATA;
                    end
                end
                bhil_pkg::PH_NSIZE: begin
                    // Long id data is skipped rounded up to whole words.
                    do_land = 1'b1;
                    target  = {1'b0, wp_inc} + {3'b000, swapped[31:2]}
                              + {32'd0, |swapped[1:0]};
                end
                bhil_pkg::PH_SKIP: begin
                    o_state.skip_left = skip_dec;
                    if (skip_dec == 32'd0) begin
                        do_land = 1'b1;
                        target  = {1'b0, wp_inc};
                    end
                end
                bhil_pkg::PH_DATA: begin
                    o_res_valid       = 1'b1;
                    o_res.status      = bhil_pkg::ST_LONG_DATA;
                    o_res.value       = w;
                    o_res.byte_count  = data_n;
                    o_res.last        = (i_state.data_left <= 16'd4);
                    o_state.data_left = i_state.data_left - {13'd0, data_n};
                    if (i_state.data_left <= 16'd4) begin
                        o_state.finished = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Move to the entry that starts at the target word.
            if (do_land) begin
                if (o_state.section_matched && (t_sat < o_state.section_end)) begin
                    o_state.phase = bhil_pkg::PH_ID;
                end else if (t_sat >= o_state.header_end) begin
                    o_res_valid      = 1'b1;
                    o_res.status     = bhil_pkg::ST_NOT_FOUND;
                    o_res.last       = 1'b1;
                    o_state.finished = 1'b1;
                end else begin
                    o_state.phase = bhil_pkg::PH_SECNAME;
                end
                if (!o_res_valid && (t_sat > wp_inc)) begin
                    o_state.phase     = bhil_pkg::PH_SKIP;
                    o_state.skip_left = t_sat - wp_inc;
                end
            end
        end
    end

endmodule
